// ----- rtl/nts_pkg.sv -----
// Shared types and constants for the neighbor table with link statistics.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package nts_pkg;

   // Field widths fixed by the item formats.
   localparam int ADDR_W     = 16;
   localparam int BYTE_W     = 8;
   localparam int ACTION_W   = 3;
   localparam int NCOUNT_W   = 6;

   // Action codes of an input item.
   localparam logic [ACTION_W-1:0] ACT_ADD       = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_RX        = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_TX        = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_CLR_COUNT = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_REPORT    = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_PURGE     = 3'd5;

   // Record kinds of a result item.
   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_ENTRY  = 1'b1;

   // Masks for one address byte and for the full address.
   localparam logic [ADDR_W-1:0] BYTE_ADDR_MASK = 16'h00FF;
   localparam logic [ADDR_W-1:0] FULL_ADDR_MASK = 16'hFFFF;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [ADDR_W-1:0]   node_address;
      logic [BYTE_W-1:0]   signal_strength;
   } req_type;

   typedef struct packed {
      logic                record_kind;
      logic [NCOUNT_W-1:0] neighbor_count;
      logic [ADDR_W-1:0]   entry_address;
      logic [BYTE_W-1:0]   entry_strength;
      logic [BYTE_W-1:0]   entry_received;
      logic [BYTE_W-1:0]   entry_sent;
      logic                last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic idx_clear;
      logic idx_inc;
      logic mem_rd;
      logic wr_update;
      logic wr_append;
      logic wr_clear;
      logic total_clear;
      logic rsp_load_hdr;
      logic rsp_load_entry;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic item_is_add;
      logic idx_at_end;
      logic hit;
      logic full;
      logic last_entry;
      logic total_zero;
      logic out_free;
   } ctl_status_type;

endpackage

// ----- rtl/nts_ctrl.sv -----
// Controller state machine of the neighbor table: sequences search, update,
// counter clearing, report and purge. Depends on nts_pkg.
`timescale 1ns / 1ps

module nts_ctrl
   import nts_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [ACTION_W-1:0] req_action,
   output logic                req_ready,
   input  ctl_status_type      status,
   output ctl_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_CHECK,
      ST_CLR,
      ST_CLR_WR,
      ST_RPT_HDR,
      ST_RPT_READ,
      ST_RPT_EMIT
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               cmd.idx_clear = 1'b1;
               unique case (req_action)
                  ACT_ADD, ACT_RX, ACT_TX: state_in = ST_LOOKUP;
                  ACT_CLR_COUNT:           state_in = ST_CLR;
                  ACT_REPORT:              state_in = ST_RPT_HDR;
                  ACT_PURGE:               cmd.total_clear = 1'b1;
                  default:                 state_in = ST_IDLE;
               endcase
            end
         end
         // Either the search ran off the end, or the next entry is read.
         ST_LOOKUP: begin
            if (status.idx_at_end) begin
               cmd.wr_append = status.item_is_add && !status.full;
               state_in      = ST_IDLE;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.hit) begin
               cmd.wr_update = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         // Clear both counters of each entry, one entry per pass.
         ST_CLR: begin
            if (status.idx_at_end) begin
               state_in = ST_IDLE;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = ST_CLR_WR;
            end
         end
         ST_CLR_WR: begin
            cmd.wr_clear = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = ST_CLR;
         end
         // Report header, then every entry in order.
         ST_RPT_HDR: begin
            if (status.out_free) begin
               cmd.rsp_load_hdr = 1'b1;
               if (status.total_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RPT_READ;
               end
            end
         end
         ST_RPT_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_RPT_EMIT;
         end
         ST_RPT_EMIT: begin
            if (status.out_free) begin
               cmd.rsp_load_entry = 1'b1;
               if (status.last_entry) begin
                  cmd.total_clear = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_RPT_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/nts_datapath.sv -----
// Datapath of the neighbor table: item register, entry memory, index and
// entry count, and the result output register. Depends on nts_pkg.
`timescale 1ns / 1ps

module nts_datapath
   import nts_pkg::*;
#(
   parameter int TABLE_CAPACITY = 16,
   parameter int ADDRESS_BYTES  = 2
) (
   input  logic           clock,
   input  logic           reset,
   input  req_type        req_data,
   input  ctl_cmd_type    cmd,
   output ctl_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_type        rsp_data
);

   localparam int CNT_W = $clog2(TABLE_CAPACITY + 1);
   localparam int IDX_W = (TABLE_CAPACITY > 1) ? $clog2(TABLE_CAPACITY) : 1;
   localparam logic [ADDR_W-1:0] ADDR_MASK =
      (ADDRESS_BYTES >= 2) ? FULL_ADDR_MASK : BYTE_ADDR_MASK;
   localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(TABLE_CAPACITY);

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [BYTE_W-1:0] strength;
      logic [BYTE_W-1:0] received;
      logic [BYTE_W-1:0] sent;
   } entry_type;

   req_type          item_ff;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] total_ff, total_in;
   entry_type        mem [TABLE_CAPACITY];
   entry_type        rdata_ff;
   entry_type        wr_entry;
   logic             mem_we;
   logic [IDX_W-1:0] wr_idx;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Status toward the controller.
   always_comb begin
      status.item_is_add = (item_ff.action == ACT_ADD);
      status.idx_at_end  = (idx_ff == total_ff);
      status.hit         = (rdata_ff.address == item_ff.node_address);
      status.full        = (total_ff == CAPACITY);
      status.last_entry  = ((idx_ff + 1'b1) == total_ff);
      status.total_zero  = (total_ff == '0);
      status.out_free    = out_free;
   end

   // Index and entry count.
   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
      total_in = total_ff;
      if (cmd.total_clear) begin
         total_in = '0;
      end else if (cmd.wr_append) begin
         total_in = total_ff + 1'b1;
      end
   end

   // Entry write: append a new neighbor, update a found one, or clear counters.
   always_comb begin
      wr_entry = rdata_ff;
      wr_idx   = idx_ff[IDX_W-1:0];
      mem_we   = cmd.wr_append || cmd.wr_update || cmd.wr_clear;
      priority if (cmd.wr_append) begin
         wr_idx   = total_ff[IDX_W-1:0];
         wr_entry = '{address: item_ff.node_address,
                      strength: item_ff.signal_strength,
                      received: '0, sent: '0};
      end else if (cmd.wr_clear) begin
         wr_entry.received = '0;
         wr_entry.sent     = '0;
      end else if (item_ff.action == ACT_RX) begin
         wr_entry.received = rdata_ff.received + 1'b1;
      end else if (item_ff.action == ACT_TX) begin
         wr_entry.sent = rdata_ff.sent + 1'b1;
      end else begin
         wr_entry.strength = item_ff.signal_strength;
      end
   end

   // Output register: header or entry record, held until taken.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.rsp_load_hdr) begin
         rsp_in                = '0;
         rsp_in.record_kind    = KIND_HEADER;
         rsp_in.neighbor_count = NCOUNT_W'(total_ff);
         rsp_in.last           = (total_ff == '0);
         rsp_valid_in          = 1'b1;
      end else if (cmd.rsp_load_entry) begin
         rsp_in.record_kind    = KIND_ENTRY;
         rsp_in.neighbor_count = '0;
         rsp_in.entry_address  = rdata_ff.address;
         rsp_in.entry_strength = rdata_ff.strength;
         rsp_in.entry_received = rdata_ff.received;
         rsp_in.entry_sent     = rdata_ff.sent;
         rsp_in.last           = ((idx_ff + 1'b1) == total_ff);
         rsp_valid_in          = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: the item has its address masked to the used bytes.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (cmd.load_item) begin
         item_ff <= '{action: req_data.action,
                      node_address: req_data.node_address & ADDR_MASK,
                      signal_strength: req_data.signal_strength};
      end
   end

   // Entry memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx] <= wr_entry;
      end
      if (cmd.mem_rd) begin
         rdata_ff <= mem[idx_ff[IDX_W-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_no_append_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_append |-> !status.full)
      else $error("append issued on a full table");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_rd |-> (idx_ff < total_ff))
      else $error("entry read beyond the entry count");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load_hdr || cmd.rsp_load_entry) |-> out_free)
      else $error("result overwritten before it was taken");

   a_total_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.total_clear |=> (total_ff == '0))
      else $error("entry count not cleared");

   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_append |=> (total_ff == $past(total_ff) + 1'b1))
      else $error("entry count did not advance on append");
`endif

endmodule

// ----- rtl/neighbor_table_link_stats.sv -----
// Top level of the neighbor table with link statistics.
// Instantiates nts_ctrl and nts_datapath; depends on nts_pkg.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  req_data  (action, address, strength)
//   rsp_      out        rsp_valid/rsp_ready  rsp_data  (header or entry record)
//
// One item at a time. An add, rx or tx item searches the entries in order, one read
// and one compare per entry, and stops at the first match; when none of the N entries
// match it scans all of them (at most TABLE_CAPACITY), as the entry memory has a
// single registered read. A counter reset and a report visit each of the N entries in
// turn, and a report also waits while rsp_ready stays low. Purge is done in the idle state.
// Reset is synchronous and empties the table; entry contents are not cleared.
`timescale 1ns / 1ps

module neighbor_table_link_stats
   import nts_pkg::*;
#(
   parameter int TABLE_CAPACITY = 16,
   parameter int ADDRESS_BYTES  = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   // Sequencing of each item.
   nts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // Table storage and result register.
   nts_datapath #(
      .TABLE_CAPACITY (TABLE_CAPACITY),
      .ADDRESS_BYTES  (ADDRESS_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for neighbor_table_link_stats, with its own table predictor.
// Depends on nts_pkg and the RTL of neighbor_table_link_stats.
`timescale 1ns / 1ps

module tb_top;
   import nts_pkg::*;

   localparam int NT_CAPACITY   = 16;
   localparam int NT_ADDR_BYTES = 2;
   localparam logic [ADDR_W-1:0] TB_ADDR_MASK =
      (NT_ADDR_BYTES >= 2) ? FULL_ADDR_MASK : BYTE_ADDR_MASK;

   // Action codes that the block must ignore.
   localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

   // Cycles the block may still spend on a search after the last record.
   localparam int DRAIN_CYCLES = 2 + 2 * NT_CAPACITY + 8;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Predicted table contents, in insertion order.
   int               model_total;
   logic [ADDR_W-1:0] model_addr     [NT_CAPACITY];
   logic [BYTE_W-1:0] model_strength [NT_CAPACITY];
   logic [BYTE_W-1:0] model_received [NT_CAPACITY];
   logic [BYTE_W-1:0] model_sent     [NT_CAPACITY];

   rsp_type expected_records[$];
   int      mismatch_count = 0;
   bit      steady_mode    = 1'b0;

   neighbor_table_link_stats #(
      .TABLE_CAPACITY(NT_CAPACITY),
      .ADDRESS_BYTES (NT_ADDR_BYTES)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   initial begin
      #8_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_mode) return 0;
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Serial search in insertion order; -1 when the address is absent.
   function automatic int find_slot(logic [ADDR_W-1:0] addr);
      for (int i = 0; i < model_total; i++) begin
         if (model_addr[i] == addr) return i;
      end
      return -1;
   endfunction

   // Applies one accepted item to the predicted table and queues the records it causes.
   function automatic void predict_table_action(req_type item);
      logic [ADDR_W-1:0] addr;
      int                slot;
      rsp_type           rec;
      addr = item.node_address & TB_ADDR_MASK;
      slot = find_slot(addr);
      case (item.action)
         ACT_ADD: begin
            if (slot >= 0) begin
               model_strength[slot] = item.signal_strength;
            end else if (model_total < NT_CAPACITY) begin
               model_addr[model_total]     = addr;
               model_strength[model_total] = item.signal_strength;
               model_received[model_total] = '0;
               model_sent[model_total]     = '0;
               model_total++;
            end
         end
         ACT_RX: begin
            if (slot >= 0) model_received[slot] = model_received[slot] + 1'b1;
         end
         ACT_TX: begin
            if (slot >= 0) model_sent[slot] = model_sent[slot] + 1'b1;
         end
         ACT_CLR_COUNT: begin
            for (int i = 0; i < model_total; i++) begin
               model_received[i] = '0;
               model_sent[i]     = '0;
            end
         end
         ACT_REPORT: begin
            rec                = '0;
            rec.record_kind    = KIND_HEADER;
            rec.neighbor_count = NCOUNT_W'(model_total);
            rec.last           = (model_total == 0);
            expected_records.push_back(rec);
            for (int i = 0; i < model_total; i++) begin
               rec                = '0;
               rec.record_kind    = KIND_ENTRY;
               rec.entry_address  = model_addr[i];
               rec.entry_strength = model_strength[i];
               rec.entry_received = model_received[i];
               rec.entry_sent     = model_sent[i];
               rec.last           = (i == model_total - 1);
               expected_records.push_back(rec);
            end
            model_total = 0;
         end
         ACT_PURGE: begin
            model_total = 0;
         end
         default: begin
         end
      endcase
   endfunction

   // Sends one item; valid stays high back to back when no idle gap is drawn.
   task automatic send_item(input req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_table_action(item);
   endtask

   task automatic send_action(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] addr,
                              input logic [BYTE_W-1:0] strength);
      req_type item;
      item.action          = act;
      item.node_address    = addr;
      item.signal_strength = strength;
      send_item(item);
   endtask

   // Result side stalls at random, except in steady stretches.
   initial begin : ready_pattern
      int span;
      rsp_ready <= 1'b0;
      forever begin
         if (steady_mode) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            span = pick_gap();
            if (span > 0) begin
               rsp_ready <= 1'b0;
               repeat (span) @(posedge clock);
            end
         end
      end
   end

   function automatic void check_field(string field_name, logic [ADDR_W-1:0] want,
                                       logic [ADDR_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, field_name, want, got);
         mismatch_count++;
      end
   endfunction

   // Each accepted record is compared with the oldest expectation.
   always @(posedge clock) begin : record_checker
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_records.size() == 0) begin
            $display("%0t: unexpected record, expected none actual %h", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = expected_records.pop_front();
            check_field("record_kind", ADDR_W'(want.record_kind),
                        ADDR_W'(rsp_data.record_kind));
            check_field("neighbor_count", ADDR_W'(want.neighbor_count),
                        ADDR_W'(rsp_data.neighbor_count));
            check_field("entry_address", want.entry_address, rsp_data.entry_address);
            check_field("entry_strength", ADDR_W'(want.entry_strength),
                        ADDR_W'(rsp_data.entry_strength));
            check_field("entry_received", ADDR_W'(want.entry_received),
                        ADDR_W'(rsp_data.entry_received));
            check_field("entry_sent", ADDR_W'(want.entry_sent),
                        ADDR_W'(rsp_data.entry_sent));
            check_field("last", ADDR_W'(want.last), ADDR_W'(rsp_data.last));
         end
      end
   end

   // Empty table: a lone header, ignored increments and spare action codes.
   task automatic test_empty_table();
      send_action(ACT_REPORT, 16'h0000, 8'h00);
      send_action(ACT_PURGE, 16'h0000, 8'h00);
      send_action(ACT_RX, 16'h1234, 8'h00);
      send_action(ACT_TX, 16'h1234, 8'hFF);
      send_action(ACT_SPARE_LO, 16'hFFFF, 8'hFF);
      send_action(ACT_SPARE_HI, 16'hA5A5, 8'h5A);
      send_action(ACT_REPORT, 16'hFFFF, 8'hFF);
   endtask

   // Address and strength extremes, updates, unknown addresses and a counter clear.
   task automatic test_field_extremes();
      send_action(ACT_ADD, 16'h0000, 8'h00);
      send_action(ACT_ADD, 16'hFFFF, 8'hFF);
      send_action(ACT_ADD, 16'h8001, 8'h7E);
      send_action(ACT_ADD, 16'h0000, 8'hA5);
      send_action(ACT_RX, 16'hFFFF, 8'h00);
      send_action(ACT_RX, 16'hFFFF, 8'h00);
      send_action(ACT_TX, 16'h0000, 8'h00);
      send_action(ACT_TX, 16'h8001, 8'h00);
      send_action(ACT_RX, 16'h7FFF, 8'h00);
      send_action(ACT_TX, 16'hFFFE, 8'h00);
      send_action(ACT_REPORT, 16'h0000, 8'h00);
      send_action(ACT_ADD, 16'h00FF, 8'h01);
      send_action(ACT_RX, 16'h00FF, 8'h00);
      send_action(ACT_TX, 16'h00FF, 8'h00);
      send_action(ACT_CLR_COUNT, 16'h0000, 8'h00);
      send_action(ACT_REPORT, 16'h0000, 8'h00);
   endtask

   // Fill the table, drop a newcomer, then report all sixteen entries.
   task automatic test_table_full();
      send_action(ACT_ADD, 16'h4242, 8'h11);
      send_action(ACT_PURGE, 16'h0000, 8'h00);
      for (int i = 0; i < NT_CAPACITY; i++) begin
         send_action(ACT_ADD, 16'h1000 + 16'(i) * 16'h0111, 8'(i * 16 + 3));
      end
      send_action(ACT_ADD, 16'hBEEF, 8'h99);
      send_action(ACT_RX, 16'hBEEF, 8'h00);
      send_action(ACT_ADD, 16'h1000, 8'hEE);
      send_action(ACT_RX, 16'h1000 + 16'(NT_CAPACITY - 1) * 16'h0111, 8'h00);
      send_action(ACT_TX, 16'h1000, 8'h00);
      send_action(ACT_REPORT, 16'h0000, 8'h00);
   endtask

   // Counters of two neighbors advance independently, first without idling.
   task automatic test_counter_run();
      steady_mode = 1'b1;
      send_action(ACT_ADD, 16'hC3C3, 8'h3C);
      send_action(ACT_ADD, 16'h3C3C, 8'hC3);
      for (int i = 0; i < 12; i++) send_action(ACT_RX, 16'h3C3C, 8'h00);
      steady_mode = 1'b0;
      for (int i = 0; i < 9; i++) send_action(ACT_TX, 16'hC3C3, 8'h00);
      send_action(ACT_REPORT, 16'h0000, 8'h00);
   endtask

   // Mostly known addresses so that updates and increments hit; some fresh ones.
   task automatic test_random_traffic(input int item_goal);
      logic [ADDR_W-1:0] pool [24];
      req_type           item;
      int                sent;
      int                roll;
      for (int i = 0; i < 24; i++) pool[i] = 16'($urandom());
      sent = 0;
      while (sent < item_goal) begin
         roll = $urandom_range(0, 99);
         item.node_address    = (roll < 88) ? pool[$urandom_range(0, 23)] : 16'($urandom());
         item.signal_strength = 8'($urandom());
         roll = $urandom_range(0, 99);
         if (roll < 34)      item.action = ACT_ADD;
         else if (roll < 58) item.action = ACT_RX;
         else if (roll < 79) item.action = ACT_TX;
         else if (roll < 84) item.action = ACT_CLR_COUNT;
         else if (roll < 93) item.action = ACT_REPORT;
         else if (roll < 96) item.action = ACT_PURGE;
         else if (roll < 98) item.action = ACT_SPARE_LO;
         else                item.action = ACT_SPARE_HI;
         send_item(item);
         sent++;
         // Alternate stretches with and without idling.
         if (sent % 40 == 0) steady_mode = !steady_mode;
      end
      steady_mode = 1'b0;
      send_action(ACT_REPORT, 16'h0000, 8'h00);
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      model_total = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_field_extremes();
      test_table_full();
      test_counter_run();
      test_random_traffic(88);

      req_valid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
